// ===== rtl/core/qcls_pkg.sv =====
package qcls_pkg;

    // fixed field widths
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned ELEM_COUNT_W = 16;
    localparam int unsigned CFG_INDEX_W  = 8;

    // default counter width for the element counter
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // register reset values
    localparam logic [BYTE_W-1:0] DELIMITER_RST = 8'd10;
    localparam logic [BYTE_W-1:0] QUOTE_RST     = 8'd34;
    localparam logic [BYTE_W-1:0] ESCAPE_RST    = 8'd34;
    localparam logic [BYTE_W-1:0] COMMENT_RST   = 8'd59;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DELIMITER = 8'd0,
        CFG_QUOTE     = 8'd1,
        CFG_ESCAPE    = 8'd2,
        CFG_COMMENT   = 8'd3
    } t_cfg_index;

    // current register values
    typedef struct packed {
        logic [BYTE_W-1:0] delimiter_byte;
        logic [BYTE_W-1:0] quote_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] comment_byte;
    } t_cfg;

    // one input word
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } t_item;

    // one result word
    typedef struct packed {
        logic [BYTE_W-1:0]       out_byte;
        logic                    is_split;
        logic                    inside_quote;
        logic                    inside_comment;
        logic                    trailing_element;
        logic [ELEM_COUNT_W-1:0] element_count;
    } t_result;

endpackage

// ===== rtl/core/qcls_config.sv =====
module qcls_config
    import qcls_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]      i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    // writes always taken, unknown indexes ignored
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_byte <= DELIMITER_RST;
            r_cfg.quote_byte     <= QUOTE_RST;
            r_cfg.escape_byte    <= ESCAPE_RST;
            r_cfg.comment_byte   <= COMMENT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DELIMITER: r_cfg.delimiter_byte <= i_cfg_data;
                CFG_QUOTE:     r_cfg.quote_byte     <= i_cfg_data;
                CFG_ESCAPE:    r_cfg.escape_byte    <= i_cfg_data;
                CFG_COMMENT:   r_cfg.comment_byte   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/qcls_input_reg.sv =====
module qcls_input_reg
    import qcls_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // refill whenever empty or the held word moves on
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/core/qcls_classifier.sv =====
module qcls_classifier
    import qcls_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  logic    i_fire,
    output t_result o_result
);

    localparam logic [COUNT_WIDTH+1:0] CountTop = {2'b00, {COUNT_WIDTH{1'b1}}};

    logic                   r_quote_open;
    logic                   r_comment_open;
    logic                   r_quote_pending;
    logic [BYTE_W-1:0]      r_prev_byte;
    logic                   r_prev_valid;
    logic [COUNT_WIDTH-1:0] r_count;

    logic                   n_quote_open;
    logic                   n_comment_open;
    logic                   n_quote_pending;
    logic [COUNT_WIDTH-1:0] n_count;

    logic                   skip;
    logic                   split;
    logic                   trailing;
    logic                   toggle;
    logic                   quote_en;
    logic [1:0]             inc;
    logic [COUNT_WIDTH+1:0] count_sum;
    logic [COUNT_WIDTH+ELEM_COUNT_W-1:0] count_ext;
    logic [BYTE_W-1:0]      b;
    logic                   eot;

    assign b        = i_item.text_byte;
    assign eot      = i_item.end_of_text;
    assign quote_en = (i_cfg.quote_byte != '0);

    // quote, comment and delimiter decisions for one byte
    always_comb begin
        n_quote_open    = r_quote_open;
        n_comment_open  = r_comment_open;
        n_quote_pending = 1'b0;
        skip            = 1'b0;
        split           = 1'b0;
        toggle          = 1'b0;
        inc             = 2'd0;

        // held quote from the byte before
        if (r_quote_pending) begin
            if (quote_en && b == i_cfg.quote_byte) begin
                skip = 1'b1;
            end else begin
                n_quote_open   = !n_quote_open;
                n_comment_open = 1'b0;
                if (i_cfg.comment_byte != '0 && i_cfg.quote_byte == i_cfg.comment_byte
                        && !n_quote_open) begin
                    n_comment_open = 1'b1;
                end
                if (i_cfg.quote_byte == i_cfg.delimiter_byte && !n_quote_open) begin
                    inc            = inc + 2'd1;
                    n_comment_open = 1'b0;
                end
            end
        end

        // quote of this byte
        if (!skip && quote_en && b == i_cfg.quote_byte && !n_comment_open) begin
            if (i_cfg.quote_byte == i_cfg.escape_byte) begin
                if (eot) begin
                    toggle = 1'b1;
                end else begin
                    n_quote_pending = 1'b1;
                    skip            = 1'b1;
                end
            end else if (r_prev_valid && r_prev_byte == i_cfg.escape_byte) begin
                skip = 1'b1;
            end else begin
                toggle = 1'b1;
            end
            if (toggle) begin
                n_quote_open   = !n_quote_open;
                n_comment_open = 1'b0;
            end
        end

        // comment start and delimiter of this byte
        if (!skip) begin
            if (i_cfg.comment_byte != '0 && b == i_cfg.comment_byte && !n_quote_open) begin
                n_comment_open = 1'b1;
            end
            if (b == i_cfg.delimiter_byte && !n_quote_open) begin
                inc            = inc + 2'd1;
                n_comment_open = 1'b0;
                split          = 1'b1;
            end
        end

        trailing = eot && !split;
        if (trailing) begin
            inc = inc + 2'd1;
        end
    end

    // saturating element count
    always_comb begin
        count_sum = {2'b00, r_count} + (COUNT_WIDTH+2)'(inc);
        if (count_sum > CountTop) begin
            n_count = {COUNT_WIDTH{1'b1}};
        end else begin
            n_count = count_sum[COUNT_WIDTH-1:0];
        end
        count_ext = {{ELEM_COUNT_W{1'b0}}, n_count};
    end

    // result word
    always_comb begin
        o_result.out_byte         = b;
        o_result.is_split         = split;
        o_result.inside_quote     = n_quote_open;
        o_result.inside_comment   = n_comment_open;
        o_result.trailing_element = trailing;
        o_result.element_count    = count_ext[ELEM_COUNT_W-1:0];
    end

    // parser state, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_open    <= 1'b0;
            r_comment_open  <= 1'b0;
            r_quote_pending <= 1'b0;
            r_prev_byte     <= '0;
            r_prev_valid    <= 1'b0;
            r_count         <= '0;
        end else if (i_fire) begin
            if (eot) begin
                r_quote_open    <= 1'b0;
                r_comment_open  <= 1'b0;
                r_quote_pending <= 1'b0;
                r_prev_byte     <= '0;
                r_prev_valid    <= 1'b0;
                r_count         <= '0;
            end else begin
                r_quote_open    <= n_quote_open;
                r_comment_open  <= n_comment_open;
                r_quote_pending <= n_quote_pending;
                r_prev_byte     <= b;
                r_prev_valid    <= 1'b1;
                r_count         <= n_count;
            end
        end
    end

endmodule

// ===== rtl/core/qcls_result_reg.sv =====
module qcls_result_reg
    import qcls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // loads while empty or while the held word is taken
    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/core/quoted_comment_aware_line_splitter.sv =====
// channel  direction  handshake               payload
// input    in         i_valid / o_ready       i_text_byte, i_end_of_text
// result   out        o_valid / i_ready       o_out_byte, o_is_split, o_inside_quote,
//                                             o_inside_comment, o_trailing_element,
//                                             o_element_count
// config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while the result side is ready; a byte accepted into the
// input register then moves through the classifier into the result register
// the classifier state updates once per byte as it moves into the result register
// synchronous active-low reset clears all valid flags, parser state and config registers
// a stalled result holds the result register and then the input register;
// a word is accepted whenever the input register is empty or moves on
module quoted_comment_aware_line_splitter
    import qcls_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [BYTE_W-1:0]       i_text_byte,
    input  logic                    i_end_of_text,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [BYTE_W-1:0]       o_out_byte,
    output logic                    o_is_split,
    output logic                    o_inside_quote,
    output logic                    o_inside_comment,
    output logic                    o_trailing_element,
    output logic [ELEM_COUNT_W-1:0] o_element_count,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [BYTE_W-1:0]       i_cfg_data
);

    t_cfg    cfg;
    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    res_ready;
    logic    fire;
    t_result cls_result;
    t_result out_result;

    assign in_item.text_byte   = i_text_byte;
    assign in_item.end_of_text = i_end_of_text;

    // held word moves into the result register
    assign fire = held_valid && res_ready;

    qcls_config u_config (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    qcls_input_reg u_input_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (res_ready),
        .o_item  (held_item)
    );

    qcls_classifier #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_classifier (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (held_item),
        .i_fire   (fire),
        .o_result (cls_result)
    );

    qcls_result_reg u_result_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_ready  (res_ready),
        .i_result (cls_result),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_out_byte         = out_result.out_byte;
    assign o_is_split         = out_result.is_split;
    assign o_inside_quote     = out_result.inside_quote;
    assign o_inside_comment   = out_result.inside_comment;
    assign o_trailing_element = out_result.trailing_element;
    assign o_element_count    = out_result.element_count;

endmodule
